[rtl/evdg_pkg.sv]
// ----------------------------------------------------------------------------
// evdg_pkg
// Shared types, constants and helpers of the energy VAD duty governor.
// ----------------------------------------------------------------------------
package evdg_pkg;

	// Default geometry
	localparam int WIN_SECONDS_DEF       = 600;
	localparam int FRAMES_PER_SECOND_DEF = 50;
	localparam int ONSET_COUNT_DEF       = 3;
	localparam int MAX_FRAME_SAMPLES_DEF = 1024;

	// Fixed-point constants (Q16 dB, Q24 filter coefficients)
	localparam logic [18:0] DB_PER_OCT     = 19'd394566;
	localparam logic [25:0] LEVEL_OFFSET   = 26'd5918490;
	localparam logic [19:0] ALPHA_DOWN     = 20'd838861;
	localparam logic [19:0] ALPHA_UP       = 20'd8389;
	localparam logic signed [31:0] FLOOR_RESET = -32'sd3932160;
	localparam logic signed [33:0] THR_LO  = -34'sd3276800;
	localparam logic signed [33:0] THR_HI  = -34'sd1638400;
	localparam logic [23:0] SILENCE_MAX    = 24'hFFFFFF;
	localparam logic [4:0]  FRAME_MS       = 5'd20;
	localparam logic [4:0]  ADJUST_SECONDS = 5'd30;
	localparam int          MIN_FILL       = 60;
	localparam logic [9:0]  WARN_SECONDS   = 10'd600;
	localparam logic signed [4:0] DELTA_MAX = 5'sd12;
	localparam logic signed [4:0] DELTA_MIN = -5'sd3;
	localparam logic [9:0]  MARGIN_MIN     = 10'd6;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BASE_MARGIN = 2'd0,
		REG_HARDCLAMP   = 2'd1,
		REG_HANG        = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  base_margin;
		logic        hardclamp;
		logic [15:0] hang;
	} cfg_t;

	// Frame processor states
	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_SQR,
		S_LEVEL,
		S_DB,
		S_IIRMUL,
		S_IIRADD,
		S_DECIDE,
		S_SEC_A,
		S_SEC_B,
		S_SEC_C,
		S_EMIT
	} back_state_t;

	// Effective margin: base plus governor delta, held in [6, base+12]
	function automatic logic [8:0] eff_margin(input logic [7:0] base,
			input logic signed [4:0] delta);
		logic signed [9:0] m;
		logic signed [9:0] hi;
		m  = $signed({2'b00, base}) + 10'(delta);
		hi = $signed({2'b00, base}) + 10'sd12;
		if (m < $signed(MARGIN_MIN)) m = $signed(MARGIN_MIN);
		if (m > hi) m = hi;
		return m[8:0];
	endfunction

endpackage

[rtl/evdg_if.sv]
// ----------------------------------------------------------------------------
// evdg_if
// Valid/ready channels for samples in and frame results out.
// ----------------------------------------------------------------------------
interface evdg_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               frame_end;

	modport source (output valid, sample, frame_end, input ready);
	modport sink   (input valid, sample, frame_end, output ready);
endinterface

interface evdg_out_if;
	logic               valid;
	logic               ready;
	logic               speech;
	logic [23:0]        silence_ms;
	logic [8:0]         margin_db;
	logic signed [15:0] floor_level;
	logic               clamped;
	logic               warn_pulse;
	logic [14:0]        window_speech_frames;
	logic [9:0]         window_seconds;

	modport source (output valid, speech, silence_ms, margin_db, floor_level, clamped,
		warn_pulse, window_speech_frames, window_seconds, input ready);
	modport sink   (input valid, speech, silence_ms, margin_db, floor_level, clamped,
		warn_pulse, window_speech_frames, window_seconds, output ready);
endinterface

[rtl/energy_vad_duty_governor.sv]
// ----------------------------------------------------------------------------
// energy_vad_duty_governor
// Energy-threshold voice activity detector with duty-cycle margin governor.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    sample[15:0] signed, frame_end
//   results   out  valid/ready    speech, silence_ms, margin_db, floor_level,
//                                 clamped, warn_pulse, window_*
//   cfg       in   cfg_we         cfg_index[1:0], cfg_data[15:0]
//
// One sample is taken per cycle; the accumulator holds off every sample
// while both frame queue slots are full.
// In the frame processor a shared log2 unit normalizes one bit a cycle and
// squares sixteen times, for the sum and then the count; a frame whose
// mean is below one skips the log. Level, filter and decision run in states
// LEVEL, DB, IIRMUL, IIRADD and DECIDE, a second boundary adds SEC_A, SEC_B
// and SEC_C, IDLE picks up the frame and EMIT hands the result out.
// A result waits in the output register; the next frame runs meanwhile.
// Reset is asynchronous; the bucket memory needs no clearing pass.
// ----------------------------------------------------------------------------
module energy_vad_duty_governor #(
	parameter int WIN_SECONDS       = evdg_pkg::WIN_SECONDS_DEF,
	parameter int FRAMES_PER_SECOND = evdg_pkg::FRAMES_PER_SECOND_DEF,
	parameter int ONSET_COUNT       = evdg_pkg::ONSET_COUNT_DEF,
	parameter int MAX_FRAME_SAMPLES = evdg_pkg::MAX_FRAME_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	evdg_in_if.sink     samples,
	evdg_out_if.source  results,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

	evdg_pkg::cfg_t   cfg_q;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	logic [31:0]      f_sum;
	logic [CNT_W-1:0] f_cnt;
	logic [31:0]      b_sum;
	logic [CNT_W-1:0] b_cnt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_margin <= 8'd10;
			cfg_q.hardclamp   <= 1'b0;
			cfg_q.hang        <= 16'd500;
		end else if (cfg_we) begin
			unique case (evdg_pkg::cfg_idx_t'(cfg_index))
				evdg_pkg::REG_BASE_MARGIN: cfg_q.base_margin <= cfg_data[7:0];
				evdg_pkg::REG_HARDCLAMP:   cfg_q.hardclamp   <= cfg_data[0];
				evdg_pkg::REG_HANG:        cfg_q.hang        <= cfg_data;
				default: ;
			endcase
		end
	end

	evdg_front #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_sum   (f_sum),
		.q_cnt   (f_cnt)
	);

	evdg_queue #(
		.W(32 + CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_sum, f_cnt}),
		.pop       (q_pop),
		.pop_data  ({b_sum, b_cnt}),
		.full      (q_full),
		.empty     (q_empty)
	);

	evdg_back #(
		.WIN_SECONDS       (WIN_SECONDS),
		.FRAMES_PER_SECOND (FRAMES_PER_SECOND),
		.ONSET_COUNT       (ONSET_COUNT),
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_sum   (b_sum),
		.q_cnt   (b_cnt),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule

[rtl/evdg_front.sv]
// ----------------------------------------------------------------------------
// evdg_front
// Sample accumulator: sums magnitudes, hands each finished frame to the queue.
// ----------------------------------------------------------------------------
module evdg_front #(
	parameter int MAX_FRAME_SAMPLES = evdg_pkg::MAX_FRAME_SAMPLES_DEF,
	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	evdg_in_if.sink            samples,
	input  logic               q_full,
	output logic               q_push,
	output logic [31:0]        q_sum,
	output logic [CNT_W-1:0]   q_cnt
);

	logic [31:0]      sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0]      mag;
	logic             take;
	logic             room;

	// Stall everything while the queue holds no free slot
	assign samples.ready = !q_full;
	assign take = samples.valid && samples.ready;
	assign room = cnt_q < CNT_W'(MAX_FRAME_SAMPLES);

	// Magnitude of a two's complement sample
	assign mag = samples.sample[15] ? (17'h10000 - {1'b0, samples.sample})
	                                : {1'b0, samples.sample};

	// Frame totals including the current sample
	assign q_sum  = room ? sum_q + 32'(mag) : sum_q;
	assign q_cnt  = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign q_push = take && samples.frame_end;

	// Accumulate, clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (samples.frame_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= q_sum;
				cnt_q <= q_cnt;
			end
		end
	end

endmodule

[rtl/evdg_queue.sv]
// ----------------------------------------------------------------------------
// evdg_queue
// Two-entry frame queue between accumulator and frame processor.
// ----------------------------------------------------------------------------
module evdg_queue #(
	parameter int W = 43
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] ent_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   n_q;

	assign full     = n_q == 2'd2;
	assign empty    = n_q == 2'd0;
	assign pop_data = ent_q[rp_q];

	// Store payload
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			n_q <= n_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/evdg_back.sv]
// ----------------------------------------------------------------------------
// evdg_back
// Frame processor: log level, noise floor, speech decision, duty governor.
// ----------------------------------------------------------------------------
module evdg_back #(
	parameter int WIN_SECONDS       = evdg_pkg::WIN_SECONDS_DEF,
	parameter int FRAMES_PER_SECOND = evdg_pkg::FRAMES_PER_SECOND_DEF,
	parameter int ONSET_COUNT       = evdg_pkg::ONSET_COUNT_DEF,
	parameter int MAX_FRAME_SAMPLES = evdg_pkg::MAX_FRAME_SAMPLES_DEF,
	localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1),
	localparam int PTR_W  = $clog2(WIN_SECONDS),
	localparam int FILL_W = $clog2(WIN_SECONDS + 1),
	localparam int WSUM_W = $clog2(WIN_SECONDS * FRAMES_PER_SECOND + 1),
	localparam int FIS_W  = $clog2(FRAMES_PER_SECOND + 1),
	localparam int CMP_W  = WSUM_W + 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  evdg_pkg::cfg_t   cfg,
	input  logic             q_empty,
	input  logic [31:0]      q_sum,
	input  logic [CNT_W-1:0] q_cnt,
	output logic             q_pop,
	evdg_out_if.source       results
);

	evdg_pkg::back_state_t state_q, state_n;

	// Log unit
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      m_q;
	logic [4:0]       p_q;
	logic [15:0]      frac_q;
	logic [3:0]       it_q;
	logic             which_q;
	logic [20:0]      lsum_q;
	logic [20:0]      lq_q;
	logic [63:0]      sq;
	logic [32:0]      sq_t;
	logic [15:0]      frac_n;
	logic [20:0]      log_now;

	// Level and floor
	logic [39:0]        prod_q;
	logic signed [25:0] db_q;
	logic [45:0]        iirp_q;
	logic               neg_q;
	logic signed [31:0] floor_q;
	logic signed [32:0] diff;
	logic [32:0]        dmag;
	logic [21:0]        step;
	logic [23:0]        lvl;

	// Decision
	logic signed [4:0] delta_q;
	logic [1:0]        onset_q;
	logic              speech_q;
	logic [23:0]       silence_q;
	logic              clamp_q;
	logic              warn_q;
	logic [8:0]        margin;
	logic signed [33:0] thr;
	logic              over;
	logic [24:0]       sil_add;
	logic [23:0]       sil_inc;
	logic [1:0]        onset_n;

	// Seconds and window
	logic [5:0]        bucket_mem [WIN_SECONDS];
	logic [5:0]        rd_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [FIS_W-1:0]  fis_q;
	logic [5:0]        sis_q;
	logic [4:0]        ssa_q;
	logic [9:0]        sam_q;
	logic [CMP_W-1:0]  total;
	logic [CMP_W-1:0]  wsum_x;
	logic [4:0]        ssa_n;
	logic              second_end;

	// Output register
	logic               out_v_q;
	logic               emit;
	logic               sqr_done;
	logic signed [31:0] fl_abs;
	logic [23:0]        fl_rnd;

	// Shared squaring step of the log2 fraction
	assign sq      = {32'b0, m_q} * {32'b0, m_q};
	assign sq_t    = sq[63:31];
	assign frac_n  = {frac_q[14:0], sq_t[32]};
	assign log_now = {p_q, frac_n};
	assign sqr_done = it_q == 4'd15;

	// Filter input difference and its magnitude
	assign diff = 33'(db_q) - 33'(floor_q);
	assign dmag = diff[32] ? 33'(-diff) : 33'(diff);
	assign step = 22'((iirp_q + 46'h800000) >> 24);
	assign lvl  = 24'((prod_q + 40'd32768) >> 16);

	// Threshold and over-threshold test
	assign margin = evdg_pkg::eff_margin(cfg.base_margin, delta_q);
	always_comb begin
		thr = 34'(floor_q) + $signed({9'b0, margin, 16'b0});
		if (thr < evdg_pkg::THR_LO) thr = evdg_pkg::THR_LO;
		if (thr > evdg_pkg::THR_HI) thr = evdg_pkg::THR_HI;
	end
	assign over    = (34'(db_q) > thr) && !clamp_q;
	assign sil_add = {1'b0, silence_q} + 25'(evdg_pkg::FRAME_MS);
	assign sil_inc = sil_add[24] ? evdg_pkg::SILENCE_MAX : sil_add[23:0];
	assign onset_n = (onset_q < 2'(ONSET_COUNT)) ? onset_q + 2'd1 : onset_q;
	assign second_end = (fis_q + FIS_W'(1)) >= FIS_W'(FRAMES_PER_SECOND);

	// Window duty terms
	assign total  = CMP_W'(fill_q) * CMP_W'(FRAMES_PER_SECOND);
	assign wsum_x = CMP_W'(wsum_q);
	assign ssa_n  = (ssa_q < evdg_pkg::ADJUST_SECONDS) ? ssa_q + 5'd1 : ssa_q;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			evdg_pkg::S_IDLE:   if (!q_empty)
				state_n = (q_sum < 32'(q_cnt)) ? evdg_pkg::S_LEVEL : evdg_pkg::S_NORM;
			evdg_pkg::S_NORM:   if (m_q[31]) state_n = evdg_pkg::S_SQR;
			evdg_pkg::S_SQR:    if (sqr_done)
				state_n = which_q ? evdg_pkg::S_LEVEL : evdg_pkg::S_NORM;
			evdg_pkg::S_LEVEL:  state_n = evdg_pkg::S_DB;
			evdg_pkg::S_DB:     state_n = evdg_pkg::S_IIRMUL;
			evdg_pkg::S_IIRMUL: state_n = evdg_pkg::S_IIRADD;
			evdg_pkg::S_IIRADD: state_n = evdg_pkg::S_DECIDE;
			evdg_pkg::S_DECIDE: state_n = second_end ? evdg_pkg::S_SEC_A : evdg_pkg::S_EMIT;
			evdg_pkg::S_SEC_A:  state_n = evdg_pkg::S_SEC_B;
			evdg_pkg::S_SEC_B:  state_n = evdg_pkg::S_SEC_C;
			evdg_pkg::S_SEC_C:  state_n = evdg_pkg::S_EMIT;
			evdg_pkg::S_EMIT:   if (!out_v_q || results.ready) state_n = evdg_pkg::S_IDLE;
			default:            state_n = evdg_pkg::S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		unique case (state_q)
			evdg_pkg::S_IDLE: q_pop = !q_empty;
			evdg_pkg::S_EMIT: emit  = !out_v_q || results.ready;
			default: begin
				q_pop = 1'b0;
				emit  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= evdg_pkg::S_IDLE;
		else         state_q <= state_n;
	end

	// Log unit datapath: normalize one bit a cycle, then sixteen squarings
	always_ff @(posedge clk) begin
		case (state_q)
			evdg_pkg::S_IDLE: begin
				cnt_q   <= q_cnt;
				m_q     <= q_sum;
				p_q     <= 5'd31;
				frac_q  <= '0;
				it_q    <= '0;
				which_q <= 1'b0;
				lq_q    <= '0;
			end
			evdg_pkg::S_NORM: if (!m_q[31]) begin
				m_q <= {m_q[30:0], 1'b0};
				p_q <= p_q - 5'd1;
			end
			evdg_pkg::S_SQR: begin
				m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				frac_q <= frac_n;
				it_q   <= it_q + 4'd1;
				if (sqr_done) begin
					if (!which_q) begin
						lsum_q  <= log_now;
						m_q     <= 32'(cnt_q);
						p_q     <= 5'd31;
						frac_q  <= '0;
						it_q    <= '0;
						which_q <= 1'b1;
					end else begin
						lq_q <= lsum_q - log_now;
					end
				end
			end
			evdg_pkg::S_LEVEL:  prod_q <= 40'(lq_q) * 40'(evdg_pkg::DB_PER_OCT);
			evdg_pkg::S_DB:     db_q   <= $signed({2'b00, lvl}) - $signed(evdg_pkg::LEVEL_OFFSET);
			evdg_pkg::S_IIRMUL: begin
				neg_q  <= diff[32];
				iirp_q <= 46'(dmag[25:0]) *
				          46'(diff[32] ? evdg_pkg::ALPHA_DOWN : evdg_pkg::ALPHA_UP);
			end
			default: ;
		endcase
	end

	// Registered bucket read at the write pointer
	always_ff @(posedge clk) begin
		rd_q <= bucket_mem[ptr_q];
		if (state_q == evdg_pkg::S_SEC_A) bucket_mem[ptr_q] <= sis_q;
	end

	// Floor, speech decision and governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= evdg_pkg::FLOOR_RESET;
			delta_q   <= '0;
			onset_q   <= '0;
			speech_q  <= 1'b0;
			silence_q <= '0;
			clamp_q   <= 1'b0;
			warn_q    <= 1'b0;
			ptr_q     <= '0;
			fill_q    <= '0;
			wsum_q    <= '0;
			fis_q     <= '0;
			sis_q     <= '0;
			ssa_q     <= '0;
			sam_q     <= '0;
		end else begin
			case (state_q)
				evdg_pkg::S_IIRADD:
					floor_q <= floor_q + (neg_q ? -32'(step) : 32'(step));
				evdg_pkg::S_DECIDE: begin
					warn_q <= 1'b0;
					if (speech_q) begin
						sis_q <= sis_q + 6'd1;
						if (over) silence_q <= '0;
						else begin
							silence_q <= sil_inc;
							if (sil_inc >= 24'(cfg.hang)) begin
								speech_q <= 1'b0;
								onset_q  <= '0;
								sis_q    <= sis_q;
							end
						end
					end else if (over) begin
						onset_q <= onset_n;
						if (onset_n >= 2'(ONSET_COUNT)) begin
							speech_q  <= 1'b1;
							silence_q <= '0;
							sis_q     <= sis_q + 6'd1;
						end else begin
							silence_q <= sil_inc;
						end
					end else begin
						onset_q   <= '0;
						silence_q <= sil_inc;
					end
					fis_q <= second_end ? '0 : fis_q + FIS_W'(1);
				end
				evdg_pkg::S_SEC_A: begin
					if (fill_q == FILL_W'(WIN_SECONDS))
						wsum_q <= wsum_q - WSUM_W'(rd_q) + WSUM_W'(sis_q);
					else begin
						fill_q <= fill_q + FILL_W'(1);
						wsum_q <= wsum_q + WSUM_W'(sis_q);
					end
					ptr_q <= (ptr_q == PTR_W'(WIN_SECONDS - 1)) ? '0 : ptr_q + PTR_W'(1);
					sis_q <= '0;
				end
				evdg_pkg::S_SEC_B: begin
					if (cfg.hardclamp) begin
						if (!clamp_q && (wsum_x << 1) > total) clamp_q <= 1'b1;
						else if (clamp_q && (wsum_x << 1) < total) clamp_q <= 1'b0;
					end else begin
						clamp_q <= 1'b0;
					end
					if (ssa_n >= evdg_pkg::ADJUST_SECONDS && fill_q >= FILL_W'(evdg_pkg::MIN_FILL)) begin
						ssa_q <= '0;
						if (wsum_x * CMP_W'(20) > total * CMP_W'(7) && delta_q < evdg_pkg::DELTA_MAX)
							delta_q <= delta_q + 5'sd1;
						else if (wsum_x * CMP_W'(20) < total * CMP_W'(3) &&
						         delta_q > evdg_pkg::DELTA_MIN)
							delta_q <= delta_q - 5'sd1;
					end else begin
						ssa_q <= ssa_n;
					end
				end
				evdg_pkg::S_SEC_C: begin
					if (delta_q >= evdg_pkg::DELTA_MAX) begin
						if (sam_q + 10'd1 >= evdg_pkg::WARN_SECONDS) begin
							warn_q <= 1'b1;
							sam_q  <= '0;
						end else begin
							sam_q <= sam_q + 10'd1;
						end
					end else begin
						sam_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Floor in 1/256 dB, rounded half away from zero
	assign fl_abs = floor_q[31] ? -floor_q : floor_q;
	assign fl_rnd = 24'((fl_abs + 32'sd128) >>> 8);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (emit) out_v_q <= 1'b1;
		else if (results.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			results.speech               <= speech_q;
			results.silence_ms           <= silence_q;
			results.margin_db            <= margin;
			results.floor_level          <= floor_q[31] ? -$signed(fl_rnd[15:0])
			                                            : $signed(fl_rnd[15:0]);
			results.clamped              <= clamp_q;
			results.warn_pulse           <= warn_q;
			results.window_speech_frames <= 15'(wsum_q);
			results.window_seconds       <= 10'(fill_q);
		end
	end

	assign results.valid = out_v_q;

	// Normalized mantissa throughout the squaring loop
	a_sqr_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == evdg_pkg::S_SQR |-> m_q[31])
		else $error("log mantissa lost its leading one");

	// Governor delta never leaves its range
	a_delta_rng: assert property (@(posedge clk) disable iff (!arst_n)
		delta_q >= evdg_pkg::DELTA_MIN && delta_q <= evdg_pkg::DELTA_MAX)
		else $error("margin delta out of range");

	// Window fill bounded by its depth
	a_fill_rng: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_SECONDS))
		else $error("window fill overran");

	// Queue is only drained when idle and nonempty
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != evdg_pkg::S_IDLE)
		else $error("frame popped without starting work");

	// A warning restarts the time-at-maximum count
	a_warn_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == evdg_pkg::S_SEC_C && $past(state_q) == evdg_pkg::S_SEC_B) |=>
		(!warn_q || sam_q == 10'd0))
		else $error("warning without restart of count");

endmodule

[dv/energy_vad_duty_governor_tb.sv]
// ----------------------------------------------------------------------------
// energy_vad_duty_governor_tb
// Self-checking bench for the energy VAD duty governor: streams sample items
// through valid/ready channels with random gaps and stalls, predicts each
// frame result in a local model of the detector and compares field by field.
// ----------------------------------------------------------------------------
module energy_vad_duty_governor_tb;

	localparam int  WIN_S     = 600;
	localparam int  FPS       = 50;
	localparam int  ONSET_N   = 3;
	localparam int  MAX_SMP   = 1024;
	localparam int  CYC_LIMIT = 1000000;
	localparam int  SETTLE    = 200;

	typedef struct {
		bit               speech;
		bit [23:0]        silence_ms;
		bit [8:0]         margin_db;
		bit signed [15:0] floor_level;
		bit               clamped;
		bit               warn_pulse;
		bit [14:0]        window_speech_frames;
		bit [9:0]         window_seconds;
	} frame_res_t;

	typedef struct {
		logic signed [15:0] smp;
		bit                 fe;
		bit                 typed;
		bit                 sp;
		int                 sil;
		int                 mar;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	evdg_pkg::cfg_idx_t cfg_index;
	logic [15:0]        cfg_data;

	evdg_in_if  smp_if ();
	evdg_out_if res_if ();

	energy_vad_duty_governor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp_if),
		.results   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Detector model state
	bit [7:0]   m_base;
	bit         m_clamp_en;
	bit [15:0]  m_hang;
	bit [31:0]  acc_sum;
	int         acc_cnt;
	longint     floor_q16;
	int         gov_delta;
	int         onset_run;
	bit         talking;
	int         quiet_ms;
	bit         duty_clamp;
	int         sec_counts [WIN_S];
	int         sec_ptr;
	int         sec_fill;
	int         win_sum;
	int         frame_idx;
	int         talk_frames;
	int         since_adjust;
	int         at_max_secs;

	frame_res_t frame_results_q [$];
	int         n_fail;
	int         n_frames;
	int         n_items;
	int         cycles;
	bit         src_idle_on;
	bit         snk_idle_on;
	bit         hold_req;

	// Q16 log2: integer part from the leading one, fraction by squaring
	function automatic longint log2_fix(bit [31:0] x);
		int       p;
		longint unsigned m;
		longint   frac;
		frac = 0;
		if (x == 0) return 0;
		p = 31;
		while (x[p] == 1'b0) p--;
		m = longint'(x) << (31 - p);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(p) << 16) | frac;
	endfunction

	// Round to nearest, ties away from zero
	function automatic longint round_shift(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic int margin_now();
		int m;
		m = int'(m_base) + gov_delta;
		if (m < 6) m = 6;
		if (m > int'(m_base) + 12) m = int'(m_base) + 12;
		return m;
	endfunction

	function automatic int add_quiet(int t);
		return (t + 20 > 16777215) ? 16777215 : t + 20;
	endfunction

	// Close one second of the ring and run the governor
	function automatic bit close_second();
		int total;
		bit warn;
		warn = 0;
		if (sec_fill == WIN_S) win_sum -= sec_counts[sec_ptr];
		else sec_fill++;
		sec_counts[sec_ptr] = talk_frames;
		win_sum += talk_frames;
		sec_ptr = (sec_ptr + 1 >= WIN_S) ? 0 : sec_ptr + 1;
		talk_frames = 0;
		total = sec_fill * FPS;
		if (m_clamp_en) begin
			if (!duty_clamp && 2 * win_sum > total) duty_clamp = 1;
			else if (duty_clamp && 2 * win_sum < total) duty_clamp = 0;
		end else begin
			duty_clamp = 0;
		end
		if (since_adjust < 30) since_adjust++;
		if (since_adjust >= 30 && sec_fill >= 60) begin
			since_adjust = 0;
			if (20 * win_sum > 7 * total && gov_delta < 12) gov_delta++;
			else if (20 * win_sum < 3 * total && gov_delta > -3) gov_delta--;
		end
		if (gov_delta >= 12) begin
			at_max_secs++;
			if (at_max_secs >= 600) begin
				warn = 1;
				at_max_secs = 0;
			end
		end else begin
			at_max_secs = 0;
		end
		return warn;
	endfunction

	// Advance the detector by one sample item; return 1 with a result at frame end
	function automatic bit detect_step(logic signed [15:0] s, bit fe, output frame_res_t r);
		bit [16:0] mag;
		longint    lq;
		longint    lvl;
		longint    diff;
		longint    thr;
		bit        over;
		bit        warn;
		mag = s[15] ? 17'h10000 - {1'b0, s} : {1'b0, s};
		warn = 0;
		if (acc_cnt < MAX_SMP) begin
			acc_sum += mag;
			acc_cnt++;
		end
		if (!fe) return 0;
		if (acc_sum < acc_cnt) lq = 0;
		else lq = log2_fix(acc_sum) - log2_fix(acc_cnt);
		lvl = ((lq * 394566 + 32768) >>> 16) - 15 * 64'sd394566;
		acc_sum = 0;
		acc_cnt = 0;
		diff = lvl - floor_q16;
		floor_q16 += round_shift(diff * ((lvl < floor_q16) ? 838861 : 8389), 24);
		thr = floor_q16 + longint'(margin_now()) * 65536;
		if (thr < -50 * 64'sd65536) thr = -50 * 64'sd65536;
		if (thr > -25 * 64'sd65536) thr = -25 * 64'sd65536;
		over = (lvl > thr) && !duty_clamp;
		if (talking) begin
			if (over) quiet_ms = 0;
			else begin
				quiet_ms = add_quiet(quiet_ms);
				if (quiet_ms >= m_hang) begin
					talking = 0;
					onset_run = 0;
				end
			end
		end else if (over) begin
			if (onset_run < ONSET_N) onset_run++;
			if (onset_run >= ONSET_N) begin
				talking = 1;
				quiet_ms = 0;
			end else quiet_ms = add_quiet(quiet_ms);
		end else begin
			onset_run = 0;
			quiet_ms = add_quiet(quiet_ms);
		end
		if (talking) talk_frames++;
		frame_idx++;
		if (frame_idx >= FPS) begin
			frame_idx = 0;
			warn = close_second();
		end
		r.speech               = talking;
		r.silence_ms           = quiet_ms[23:0];
		r.margin_db            = 9'(margin_now());
		r.floor_level          = 16'(round_shift(floor_q16, 8));
		r.clamped              = duty_clamp;
		r.warn_pulse           = warn;
		r.window_speech_frames = win_sum[14:0];
		r.window_seconds       = sec_fill[9:0];
		return 1;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYC_LIMIT) begin
				$display("timeout after %0d cycles, %0d frames pending", cycles,
					frame_results_q.size());
				$display("energy_vad_duty_governor test failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, occasional long hold-off
	initial begin
		int stall;
		res_if.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_if.ready <= 0;
				repeat (600) @(posedge clk);
				hold_req = 0;
			end
			stall = snk_idle_on ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				res_if.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1;
			do @(posedge clk); while (!(res_if.valid && res_if.ready));
			if ($urandom_range(0, 63) == 0) snk_idle_on = !snk_idle_on;
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			n_fail++;
			if (n_fail <= 10)
				$display("frame %0d %s mismatch: expected %0d got %0d", n_frames, name,
					exp_v, act_v);
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		frame_res_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (frame_results_q.size() == 0) begin
				n_fail++;
				if (n_fail <= 10) $display("unexpected result item at cycle %0d", cycles);
			end else begin
				e = frame_results_q.pop_front();
				check_field("speech", e.speech, res_if.speech);
				check_field("silence_ms", e.silence_ms, res_if.silence_ms);
				check_field("margin_db", e.margin_db, res_if.margin_db);
				check_field("floor_level", e.floor_level, res_if.floor_level);
				check_field("clamped", e.clamped, res_if.clamped);
				check_field("warn_pulse", e.warn_pulse, res_if.warn_pulse);
				check_field("window_speech_frames", e.window_speech_frames,
					res_if.window_speech_frames);
				check_field("window_seconds", e.window_seconds, res_if.window_seconds);
			end
			n_frames++;
		end
	end

	task automatic write_reg(evdg_pkg::cfg_idx_t idx, int val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		@(posedge clk);
		cfg_we    <= 0;
		@(posedge clk);
		case (idx)
			evdg_pkg::REG_BASE_MARGIN: m_base     = val[7:0];
			evdg_pkg::REG_HARDCLAMP:   m_clamp_en = val[0];
			evdg_pkg::REG_HANG:        m_hang     = val[15:0];
			default: ;
		endcase
	endtask

	// Offer one sample item, wait for it to be taken, and predict
	task automatic send_sample(logic signed [15:0] s, bit fe, bit typed = 0,
			bit sp = 0, int sil = 0, int mar = 0);
		int gap;
		frame_res_t r;
		gap = src_idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			smp_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid     <= 1;
		smp_if.sample    <= s;
		smp_if.frame_end <= fe;
		do @(posedge clk); while (!(smp_if.valid && smp_if.ready));
		n_items++;
		if (detect_step(s, fe, r)) begin
			if (typed) begin
				r.speech     = sp;
				r.silence_ms = 24'(sil);
				r.margin_db  = 9'(mar);
			end
			frame_results_q.push_back(r);
		end
		if ($urandom_range(0, 63) == 0) src_idle_on = !src_idle_on;
	endtask

	// Drop valid and hold until every expected result has come, then settle
	task automatic drain();
		smp_if.valid <= 0;
		@(posedge clk);
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Random frames: bursts of loud and quiet frames, some noise
	task automatic random_frames(int n);
		int  sent;
		int  len;
		bit  loud;
		bit  noisy;
		logic signed [15:0] s;
		sent = 0;
		loud = 0;
		while (sent < n) begin
			if ($urandom_range(0, 4) == 0) loud = !loud;
			noisy = ($urandom_range(0, 9) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				if (noisy || loud) s = 16'($urandom);
				else s = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
					: -16'($urandom_range(0, 63));
				send_sample(s, i == len - 1);
				sent++;
			end
		end
	endtask

	stim_row_t dir_rows [] = '{
		'{16'sd0,       1, 1, 0, 20, 10},
		'{-16'sd32768,  1, 1, 0, 40, 10},
		'{16'sd32767,   1, 1, 0, 60, 10},
		'{-16'sd32768,  0, 0, 0, 0, 0},
		'{16'sd32767,   1, 1, 1, 0, 10},
		'{16'sd0,       1, 1, 1, 20, 10},
		'{16'sd1,       0, 0, 0, 0, 0},
		'{-16'sd1,      0, 0, 0, 0, 0},
		'{16'sd0,       1, 0, 0, 0, 0},
		'{16'sh5555,    0, 0, 0, 0, 0},
		'{-16'sh5556,   1, 0, 0, 0, 0},
		'{16'sh2AAA,    1, 0, 0, 0, 0},
		'{16'sd255,     1, 0, 0, 0, 0},
		'{-16'sd256,    1, 0, 0, 0, 0},
		'{16'sd2,       0, 0, 0, 0, 0},
		'{16'sd3,       1, 0, 0, 0, 0},
		'{16'sh7F00,    1, 0, 0, 0, 0},
		'{-16'sh0F0F,   1, 0, 0, 0, 0},
		'{16'sd0,       1, 0, 0, 0, 0},
		'{16'sd0,       1, 0, 0, 0, 0}
	};

	// Main sequence
	initial begin
		arst_n           = 0;
		cfg_we           = 0;
		cfg_index        = evdg_pkg::REG_BASE_MARGIN;
		cfg_data         = 0;
		smp_if.valid     = 0;
		smp_if.sample    = 0;
		smp_if.frame_end = 0;
		n_fail = 0; n_frames = 0; n_items = 0;
		src_idle_on = 0; snk_idle_on = 0; hold_req = 0;
		m_base = 10; m_clamp_en = 0; m_hang = 500;
		acc_sum = 0; acc_cnt = 0; floor_q16 = -60 * 64'sd65536;
		gov_delta = 0; onset_run = 0; talking = 0; quiet_ms = 0; duty_clamp = 0;
		sec_ptr = 0; sec_fill = 0; win_sum = 0; frame_idx = 0; talk_frames = 0;
		since_adjust = 0; at_max_secs = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed rows under reset settings
		foreach (dir_rows[i])
			send_sample(dir_rows[i].smp, dir_rows[i].fe, dir_rows[i].typed,
				dir_rows[i].sp, dir_rows[i].sil, dir_rows[i].mar);
		drain();

		// Lowest margin, clamp on, zero hang
		write_reg(evdg_pkg::REG_BASE_MARGIN, 0);
		write_reg(evdg_pkg::REG_HARDCLAMP, 1);
		write_reg(evdg_pkg::REG_HANG, 0);
		src_idle_on = 1;
		snk_idle_on = 1;
		random_frames(300);
		drain();

		// Highest margin, longest hang; hold the result side off for a while
		write_reg(evdg_pkg::REG_BASE_MARGIN, 255);
		write_reg(evdg_pkg::REG_HARDCLAMP, 0);
		write_reg(evdg_pkg::REG_HANG, 65535);
		hold_req = 1;
		src_idle_on = 0;
		random_frames(150);
		drain();
		random_frames(150);
		drain();

		// Mid settings
		write_reg(evdg_pkg::REG_BASE_MARGIN, 10);
		write_reg(evdg_pkg::REG_HARDCLAMP, 1);
		write_reg(evdg_pkg::REG_HANG, 40);
		random_frames(300);
		drain();

		$display("covered %0d sample items and %0d frame results over four settings",
			n_items, n_frames);
		if (n_fail == 0) begin
			$display("energy_vad_duty_governor test passed");
		end else begin
			$display("%0d mismatches", n_fail);
			$display("energy_vad_duty_governor test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/evdg_pkg.sv
rtl/evdg_if.sv
rtl/evdg_front.sv
rtl/evdg_queue.sv
rtl/evdg_back.sv
rtl/energy_vad_duty_governor.sv
dv/energy_vad_duty_governor_tb.sv
